### rtl/core/alarm_clock_key_setter_defines.svh
// Assertion macros for the alarm clock key setter.
// Used by acks_core under rtl/core; expects clk_i and rst_ni in scope.
`ifndef ALARM_CLOCK_KEY_SETTER_DEFINES_SVH
`define ALARM_CLOCK_KEY_SETTER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define ACKS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("acks assertion failed");

// Check that cons holds in the cycle after ante.
`define ACKS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("acks assertion failed");

`endif

### rtl/core/acks_pkg.sv
// Shared types and constants for the alarm clock key setter.
// No dependencies; all rtl/core modules refer to it by scoped names.
package acks_pkg;

  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 88;
  localparam int unsigned OUT_PAD_W  = 7;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_TIME   = 2'd1,
    MODE_ALARM  = 2'd2
  } mode_e;

  localparam logic [7:0] KEY_LEFT    = 8'h25;
  localparam logic [7:0] KEY_RIGHT   = 8'h27;
  localparam logic [7:0] KEY_ENTER   = 8'h0D;
  localparam logic [7:0] KEY_ESC     = 8'h1B;
  localparam logic [7:0] KEY_DIGIT_0 = 8'h30;
  localparam logic [7:0] KEY_DIGIT_9 = 8'h39;

  localparam logic [7:0] ALARM_HOUR_RST   = 8'h07;
  localparam logic [7:0] ALARM_MINUTE_RST = 8'h30;

  typedef struct packed {
    logic        action;
    logic [7:0]  key_code;
    logic [15:0] cur_year;
    logic [7:0]  cur_month;
    logic [7:0]  cur_day;
    logic [7:0]  cur_weekday;
    logic [7:0]  cur_hour;
    logic [7:0]  cur_minute;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  cursor_index;
    logic        buzzer_on;
    logic        muted;
    logic        rtc_write;
    logic [15:0] edit_year;
    logic [7:0]  edit_month;
    logic [7:0]  edit_day;
    logic [7:0]  edit_weekday;
    logic [15:0] edit_clock;
    logic [7:0]  alarm_hour_out;
    logic [7:0]  alarm_minute_out;
  } out_item_t;

endpackage

### rtl/core/acks_in_reg.sv
// Input register of the alarm clock key setter: holds one accepted item.
// Depends on acks_pkg.
module acks_in_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  acks_pkg::in_item_t in_item_i,
  input  logic             pop_i,
  output logic             item_valid_o,
  output acks_pkg::in_item_t item_o
);

  logic               valid_q, valid_d;
  acks_pkg::in_item_t item_q;
  logic               load;

  // Refill in the same cycle the held item moves on.
  assign in_ready_o = !valid_q || pop_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

### rtl/core/acks_core.sv
// State registers and per-item update of the alarm clock key setter.
// Depends on acks_pkg and alarm_clock_key_setter_defines.svh.
`include "alarm_clock_key_setter_defines.svh"

module acks_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  acks_pkg::in_item_t  item_i,
  output acks_pkg::out_item_t result_o
);

  localparam logic [3:0] CUR_YEAR_TENS  = 4'd0;
  localparam logic [3:0] CUR_YEAR_UNITS = 4'd1;
  localparam logic [3:0] CUR_MONTH_HI   = 4'd2;
  localparam logic [3:0] CUR_MONTH_LO   = 4'd3;
  localparam logic [3:0] CUR_DAY_HI     = 4'd4;
  localparam logic [3:0] CUR_DAY_LO     = 4'd5;
  localparam logic [3:0] CUR_WEEKDAY    = 4'd6;
  localparam logic [3:0] CUR_HOUR_HI    = 4'd7;
  localparam logic [3:0] CUR_HOUR_LO    = 4'd8;
  localparam logic [3:0] CUR_MINUTE_HI  = 4'd9;
  localparam logic [3:0] CUR_TIME_LAST  = 4'd10;
  localparam logic [3:0] CUR_AL_HOUR_HI = 4'd0;
  localparam logic [3:0] CUR_AL_HOUR_LO = 4'd1;
  localparam logic [3:0] CUR_AL_MIN_HI  = 4'd2;
  localparam logic [3:0] CUR_ALARM_LAST = 4'd3;

  acks_pkg::mode_e mode_q, mode_d;
  logic [3:0]  cursor_q, cursor_d;
  logic        buzzer_q, buzzer_d;
  logic        mute_q, mute_d;
  logic [15:0] year_q, year_d;
  logic [7:0]  month_q, month_d;
  logic [7:0]  day_q, day_d;
  logic [7:0]  weekday_q, weekday_d;
  logic [7:0]  hour_q, hour_d;
  logic [7:0]  minute_q, minute_d;
  logic [7:0]  al_edit_hour_q, al_edit_hour_d;
  logic [7:0]  al_edit_minute_q, al_edit_minute_d;
  logic [7:0]  al_hour_q, al_hour_d;
  logic [7:0]  al_minute_q, al_minute_d;
  logic        rtc_write;
  logic        is_digit;
  logic [3:0]  digit;
  logic [3:0]  cursor_right;
  logic [3:0]  cursor_left;
  logic        alarm_match;

  assign is_digit = (item_i.key_code >= acks_pkg::KEY_DIGIT_0)
                 && (item_i.key_code <= acks_pkg::KEY_DIGIT_9);
  assign digit    = item_i.key_code[3:0];
  assign alarm_match = (item_i.cur_hour == al_hour_q) && (item_i.cur_minute == al_minute_q);

  // In time and alarm modes the cursor moves with wraparound; out-of-range positions
  // wrap to the start on right and land one below the last position on left.
  always_comb begin
    cursor_right = cursor_q;
    cursor_left  = cursor_q;
    case (mode_q)
      acks_pkg::MODE_TIME: begin
        cursor_right = (cursor_q < CUR_TIME_LAST) ? cursor_q + 4'd1 : CUR_YEAR_TENS;
        if (cursor_q == CUR_YEAR_TENS) begin
          cursor_left = CUR_TIME_LAST;
        end else if (cursor_q <= CUR_TIME_LAST) begin
          cursor_left = cursor_q - 4'd1;
        end else begin
          cursor_left = CUR_MINUTE_HI;
        end
      end
      acks_pkg::MODE_ALARM: begin
        cursor_right = (cursor_q < CUR_ALARM_LAST) ? cursor_q + 4'd1 : CUR_AL_HOUR_HI;
        if (cursor_q == CUR_AL_HOUR_HI) begin
          cursor_left = CUR_ALARM_LAST;
        end else if (cursor_q <= CUR_ALARM_LAST) begin
          cursor_left = cursor_q - 4'd1;
        end else begin
          cursor_left = CUR_AL_MIN_HI;
        end
      end
      default: begin
        cursor_right = cursor_q;
        cursor_left  = cursor_q;
      end
    endcase
  end

  always_comb begin
    mode_d           = mode_q;
    cursor_d         = cursor_q;
    buzzer_d         = buzzer_q;
    mute_d           = mute_q;
    year_d           = year_q;
    month_d          = month_q;
    day_d            = day_q;
    weekday_d        = weekday_q;
    hour_d           = hour_q;
    minute_d         = minute_q;
    al_edit_hour_d   = al_edit_hour_q;
    al_edit_minute_d = al_edit_minute_q;
    al_hour_d        = al_hour_q;
    al_minute_d      = al_minute_q;
    rtc_write        = 1'b0;

    if (item_i.action) begin
      if (alarm_match) begin
        buzzer_d = mute_q ? 1'b0 : !buzzer_q;
      end else begin
        mute_d   = 1'b0;
        buzzer_d = 1'b0;
      end
    end else if (is_digit) begin
      case (mode_q)
        acks_pkg::MODE_TIME: begin
          case (cursor_q)
            CUR_YEAR_TENS:  year_d[7:4]    = digit;
            CUR_YEAR_UNITS: year_d[3:0]    = digit;
            CUR_MONTH_HI:   month_d[7:4]   = digit;
            CUR_MONTH_LO:   month_d[3:0]   = digit;
            CUR_DAY_HI:     day_d[7:4]     = digit;
            CUR_DAY_LO:     day_d[3:0]     = digit;
            CUR_WEEKDAY:    weekday_d[3:0] = digit;
            CUR_HOUR_HI:    hour_d[7:4]    = digit;
            CUR_HOUR_LO:    hour_d[3:0]    = digit;
            CUR_MINUTE_HI:  minute_d[7:4]  = digit;
            default:        minute_d[3:0]  = digit;
          endcase
          cursor_d = cursor_right;
        end
        acks_pkg::MODE_ALARM: begin
          case (cursor_q)
            CUR_AL_HOUR_HI: al_edit_hour_d[7:4]   = digit;
            CUR_AL_HOUR_LO: al_edit_hour_d[3:0]   = digit;
            CUR_AL_MIN_HI:  al_edit_minute_d[7:4] = digit;
            default:        al_edit_minute_d[3:0] = digit;
          endcase
          cursor_d = cursor_right;
        end
        default: begin
          cursor_d = cursor_q;
        end
      endcase
    end else if (item_i.key_code == acks_pkg::KEY_LEFT) begin
      cursor_d = cursor_left;
    end else if (item_i.key_code == acks_pkg::KEY_RIGHT) begin
      cursor_d = cursor_right;
    end else if (item_i.key_code == acks_pkg::KEY_ENTER) begin
      case (mode_q)
        acks_pkg::MODE_NORMAL: begin
          mode_d    = acks_pkg::MODE_TIME;
          year_d    = item_i.cur_year;
          month_d   = item_i.cur_month;
          day_d     = item_i.cur_day;
          weekday_d = item_i.cur_weekday;
          hour_d    = item_i.cur_hour;
          minute_d  = item_i.cur_minute;
          cursor_d  = CUR_YEAR_TENS;
        end
        acks_pkg::MODE_TIME: begin
          mode_d           = acks_pkg::MODE_ALARM;
          rtc_write        = 1'b1;
          al_edit_hour_d   = al_hour_q;
          al_edit_minute_d = al_minute_q;
          cursor_d         = CUR_AL_HOUR_HI;
        end
        default: begin
          // commit the edited alarm, keep the cursor
          mode_d      = acks_pkg::MODE_NORMAL;
          al_hour_d   = al_edit_hour_q;
          al_minute_d = al_edit_minute_q;
        end
      endcase
    end else if (item_i.key_code == acks_pkg::KEY_ESC) begin
      if (mode_q == acks_pkg::MODE_NORMAL) begin
        mute_d = 1'b1;
      end else begin
        mode_d = acks_pkg::MODE_NORMAL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q           <= acks_pkg::MODE_NORMAL;
      cursor_q         <= 4'd0;
      buzzer_q         <= 1'b0;
      mute_q           <= 1'b0;
      year_q           <= 16'd0;
      month_q          <= 8'd0;
      day_q            <= 8'd0;
      weekday_q        <= 8'd0;
      hour_q           <= 8'd0;
      minute_q         <= 8'd0;
      al_edit_hour_q   <= 8'd0;
      al_edit_minute_q <= 8'd0;
      al_hour_q        <= acks_pkg::ALARM_HOUR_RST;
      al_minute_q      <= acks_pkg::ALARM_MINUTE_RST;
    end else if (step_i) begin
      mode_q           <= mode_d;
      cursor_q         <= cursor_d;
      buzzer_q         <= buzzer_d;
      mute_q           <= mute_d;
      year_q           <= year_d;
      month_q          <= month_d;
      day_q            <= day_d;
      weekday_q        <= weekday_d;
      hour_q           <= hour_d;
      minute_q         <= minute_d;
      al_edit_hour_q   <= al_edit_hour_d;
      al_edit_minute_q <= al_edit_minute_d;
      al_hour_q        <= al_hour_d;
      al_minute_q      <= al_minute_d;
    end
  end

  always_comb begin
    result_o.mode             = mode_d;
    result_o.cursor_index     = cursor_d;
    result_o.buzzer_on        = buzzer_d;
    result_o.muted            = mute_d;
    result_o.rtc_write        = rtc_write;
    result_o.edit_year        = year_d;
    result_o.edit_month       = month_d;
    result_o.edit_day         = day_d;
    result_o.edit_weekday     = weekday_d;
    result_o.edit_clock       = {hour_d, minute_d};
    result_o.alarm_hour_out   = al_hour_d;
    result_o.alarm_minute_out = al_minute_d;
  end

  `ACKS_ASSERT_NOW(a_rtc_only_from_time, step_i && rtc_write, mode_q == acks_pkg::MODE_TIME)
  `ACKS_ASSERT_NEXT(a_tick_keeps_mode, step_i && item_i.action, mode_q == $past(mode_q))
  `ACKS_ASSERT_NEXT(a_muted_tick_silent, step_i && item_i.action && mute_q, !buzzer_q)
  `ACKS_ASSERT_NOW(a_time_cursor_range, mode_q == acks_pkg::MODE_TIME, cursor_q <= CUR_TIME_LAST)
  `ACKS_ASSERT_NEXT(a_idle_keeps_alarm, !step_i, $stable(al_hour_q) && $stable(al_minute_q))

endmodule

### rtl/core/acks_out_reg.sv
// Result register of the alarm clock key setter.
// Depends on acks_pkg.
module acks_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_req_i,
  output logic                load_o,
  input  acks_pkg::out_item_t result_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output acks_pkg::out_item_t out_item_o
);

  logic                valid_q, valid_d;
  acks_pkg::out_item_t item_q;

  // Take a new result when empty or when the held one leaves this cycle.
  assign load_o = load_req_i && (!valid_q || out_ready_i);

  always_comb begin
    valid_d = valid_q;
    if (load_o) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_o) begin
      item_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

### rtl/core/alarm_clock_key_setter.sv
// Alarm clock key setter: keypad controller for setting time and alarm.
// Depends on acks_pkg, acks_in_reg, acks_core and acks_out_reg.
//
// Each item is a key press (tuser low) or an alarm check tick (tuser high)
// and yields exactly one result item showing the state after it. One item
// is taken every clock cycle while the result side does not stall. An item
// passes the input register, then its result the result register, before
// the result is offered on the master side. The state update in acks_core
// reads the state the previous item left. Backpressure on the result side
// stalls the input side only once the input register is full. No clearing
// pass after reset.
module alarm_clock_key_setter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [7:0] key_code, [23:8] cur_year, [31:24] cur_month, [39:32] cur_day,
  // [47:40] cur_weekday, [55:48] cur_hour, [63:56] cur_minute
  input  logic [acks_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,
  // [0] action
  input  logic                                s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [1:0] mode, [5:2] cursor_index, [6] buzzer_on, [7] muted, [8] rtc_write,
  // [24:9] edit_year, [32:25] edit_month, [40:33] edit_day,
  // [48:41] edit_weekday, [64:49] edit_clock, [72:65] alarm_hour_out,
  // [80:73] alarm_minute_out, [87:81] zero
  output logic [acks_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o
);

  acks_pkg::in_item_t  in_item;
  acks_pkg::in_item_t  held_item;
  acks_pkg::out_item_t result;
  acks_pkg::out_item_t out_item;
  logic                held_valid;
  logic                step;

  always_comb begin
    in_item.action      = s_axis_tuser_i;
    in_item.key_code    = s_axis_tdata_i[7:0];
    in_item.cur_year    = s_axis_tdata_i[23:8];
    in_item.cur_month   = s_axis_tdata_i[31:24];
    in_item.cur_day     = s_axis_tdata_i[39:32];
    in_item.cur_weekday = s_axis_tdata_i[47:40];
    in_item.cur_hour    = s_axis_tdata_i[55:48];
    in_item.cur_minute  = s_axis_tdata_i[63:56];
  end

  acks_in_reg u_in_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .in_item_i    (in_item),
    .pop_i        (step),
    .item_valid_o (held_valid),
    .item_o       (held_item)
  );

  acks_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (held_item),
    .result_o (result)
  );

  acks_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_req_i  (held_valid),
    .load_o      (step),
    .result_i    (result),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_item_o  (out_item)
  );

  assign m_axis_tdata_o = {
    {acks_pkg::OUT_PAD_W{1'b0}},
    out_item.alarm_minute_out,
    out_item.alarm_hour_out,
    out_item.edit_clock,
    out_item.edit_weekday,
    out_item.edit_day,
    out_item.edit_month,
    out_item.edit_year,
    out_item.rtc_write,
    out_item.muted,
    out_item.buzzer_on,
    out_item.cursor_index,
    out_item.mode
  };

endmodule
